[design/olb_pkg.sv]
package olb_pkg;

   localparam int ACTION_BITS = 2;
   localparam int OUT_BITS    = 8;
   localparam int LIGHT_BITS  = 2;
   localparam int DELAY_BITS  = 4;
   localparam int LIMIT_BITS  = 8;
   localparam int ADDR_BITS   = 2;
   localparam int DATA_BITS   = 8;

   // input actions
   localparam logic [ACTION_BITS-1:0] ACT_TICK   = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_ARRIVE = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_ENTER  = 2'd2;

   // light codes
   localparam logic [LIGHT_BITS-1:0] LIGHT_RED   = 2'd0;
   localparam logic [LIGHT_BITS-1:0] LIGHT_NORTH = 2'd1;
   localparam logic [LIGHT_BITS-1:0] LIGHT_SOUTH = 2'd2;

   // register addresses
   localparam logic [ADDR_BITS-1:0] CSR_SWAP_LIMIT = 2'd0;
   localparam logic [ADDR_BITS-1:0] CSR_RECHECK    = 2'd1;
   localparam logic [ADDR_BITS-1:0] CSR_CLEARANCE  = 2'd2;

   localparam logic [LIMIT_BITS-1:0] SWAP_LIMIT_RESET = 8'd5;
   localparam logic [DELAY_BITS-1:0] RECHECK_RESET    = 4'd1;
   localparam logic [DELAY_BITS-1:0] CLEARANCE_RESET  = 4'd5;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic                   direction;
   } item_type;

   typedef struct packed {
      logic [LIMIT_BITS-1:0] swap_limit;
      logic [DELAY_BITS-1:0] recheck_ticks;
      logic [DELAY_BITS-1:0] clearance_ticks;
   } cfg_type;

   typedef struct packed {
      logic [LIGHT_BITS-1:0] light;
      logic [OUT_BITS-1:0]   north_waiting;
      logic [OUT_BITS-1:0]   south_waiting;
      logic [OUT_BITS-1:0]   on_bridge;
      logic                  travel_dir;
      logic                  error_flag;
   } result_type;

   // a delay of zero counts as one
   function automatic logic [DELAY_BITS-1:0] at_least_one(input logic [DELAY_BITS-1:0] v);
      return (v == '0) ? DELAY_BITS'(1) : v;
   endfunction

endpackage

[design/olb_req_if.sv]
interface olb_req_if;
   logic                            valid;
   logic                            ready;
   logic [olb_pkg::ACTION_BITS-1:0] action;
   logic                            direction;

   modport source (output valid, action, direction, input ready);
   modport sink   (input valid, action, direction, output ready);
endinterface

[design/olb_rsp_if.sv]
interface olb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [olb_pkg::LIGHT_BITS-1:0] light;
   logic [olb_pkg::OUT_BITS-1:0]   north_waiting;
   logic [olb_pkg::OUT_BITS-1:0]   south_waiting;
   logic [olb_pkg::OUT_BITS-1:0]   on_bridge;
   logic                           travel_dir;
   logic                           error_flag;

   modport source (output valid, light, north_waiting, south_waiting, on_bridge, travel_dir,
                   error_flag, input ready);
   modport sink   (input valid, light, north_waiting, south_waiting, on_bridge, travel_dir,
                   error_flag, output ready);
endinterface

[design/olb_csr_if.sv]
interface olb_csr_if;
   logic                          valid;
   logic                          ready;
   logic [olb_pkg::ADDR_BITS-1:0] addr;
   logic [olb_pkg::DATA_BITS-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

[design/olb_in_stage.sv]
module olb_in_stage (
   input  logic              clock,
   input  logic              reset,
   olb_req_if.sink           req_chan,
   input  logic              advance,
   output logic              item_valid,
   output olb_pkg::item_type item
);

   logic              valid_ff;
   olb_pkg::item_type item_ff;
   logic              take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.action    <= req_chan.action;
         item_ff.direction <= req_chan.direction;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[design/olb_engine.sv]
module olb_engine #(
   parameter int CROSS_TICKS = 5,
   parameter int COUNT_BITS  = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  olb_pkg::item_type   item,
   input  olb_pkg::cfg_type    cfg,
   output olb_pkg::result_type result
);

   localparam int CMP_BITS  = (COUNT_BITS > olb_pkg::LIMIT_BITS) ? COUNT_BITS
                                                                 : olb_pkg::LIMIT_BITS;
   localparam int LEAVE_IDX = 1 % CROSS_TICKS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0]           north_ff, north_in;
   logic [COUNT_BITS-1:0]           south_ff, south_in;
   logic [COUNT_BITS-1:0]           bridge_ff, bridge_in;
   logic [COUNT_BITS-1:0]           passed_ff, passed_in;
   logic                            heading_ff, heading_in;
   logic [olb_pkg::LIGHT_BITS-1:0]  light_ff, light_in;
   logic                            side_ff, side_in;
   logic [olb_pkg::DELAY_BITS-1:0]  countdown_ff, countdown_in;
   // slot 0 is the one filling now; slot k empties k ticks from now
   logic [COUNT_BITS-1:0]           slots_ff [CROSS_TICKS];
   logic [COUNT_BITS-1:0]           slots_in [CROSS_TICKS];

   logic                  err;
   logic [COUNT_BITS-1:0] leaving;
   logic [COUNT_BITS-1:0] own;
   logic [COUNT_BITS-1:0] other;
   logic                  clearing;

   always_comb begin
      north_in     = north_ff;
      south_in     = south_ff;
      bridge_in    = bridge_ff;
      passed_in    = passed_ff;
      heading_in   = heading_ff;
      light_in     = light_ff;
      side_in      = side_ff;
      countdown_in = countdown_ff;
      slots_in     = slots_ff;
      err          = 1'b0;
      leaving      = slots_ff[LEAVE_IDX];
      own          = side_ff ? south_ff : north_ff;
      other        = side_ff ? north_ff : south_ff;
      clearing     = 1'b0;

      if (fire) begin
         case (item.action)
            olb_pkg::ACT_TICK: begin
               // rotate the exit line, the slot entered fresh starts empty
               for (int k = 0; k < CROSS_TICKS; k++) begin
                  if (k == CROSS_TICKS - 1) begin
                     slots_in[k] = slots_ff[0];
                  end else begin
                     slots_in[k] = slots_ff[k+1];
                  end
               end
               slots_in[0] = '0;

               if (leaving > bridge_ff) begin
                  err       = 1'b1;
                  bridge_in = '0;
               end else begin
                  bridge_in = bridge_ff - leaving;
               end

               if (countdown_ff > olb_pkg::DELAY_BITS'(1)) begin
                  countdown_in = countdown_ff - olb_pkg::DELAY_BITS'(1);
               end else if (own != '0 &&
                            (CMP_BITS'(passed_ff) <= CMP_BITS'(cfg.swap_limit) ||
                             other == '0)) begin
                  light_in     = side_ff ? olb_pkg::LIGHT_SOUTH : olb_pkg::LIGHT_NORTH;
                  countdown_in = olb_pkg::at_least_one(cfg.recheck_ticks);
               end else begin
                  clearing     = bridge_in != '0 && other != '0 && heading_ff == side_ff;
                  light_in     = olb_pkg::LIGHT_RED;
                  passed_in    = '0;
                  side_in      = !side_ff;
                  countdown_in = olb_pkg::at_least_one(clearing ? cfg.clearance_ticks
                                                                : cfg.recheck_ticks);
               end
            end

            olb_pkg::ACT_ARRIVE: begin
               if (item.direction) begin
                  if (south_ff == COUNT_MAX) err = 1'b1;
                  else                       south_in = south_ff + 1'b1;
               end else begin
                  if (north_ff == COUNT_MAX) err = 1'b1;
                  else                       north_in = north_ff + 1'b1;
               end
            end

            olb_pkg::ACT_ENTER: begin
               if (item.direction) begin
                  if (south_ff == '0) err = 1'b1;
                  else                south_in = south_ff - 1'b1;
               end else begin
                  if (north_ff == '0) err = 1'b1;
                  else                north_in = north_ff - 1'b1;
               end
               heading_in = item.direction;
               if (passed_ff == COUNT_MAX)   err = 1'b1;
               else                          passed_in = passed_ff + 1'b1;
               if (bridge_ff == COUNT_MAX)   err = 1'b1;
               else                          bridge_in = bridge_ff + 1'b1;
               if (slots_ff[0] == COUNT_MAX) err = 1'b1;
               else                          slots_in[0] = slots_ff[0] + 1'b1;
            end

            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         north_ff     <= '0;
         south_ff     <= '0;
         bridge_ff    <= '0;
         passed_ff    <= '0;
         heading_ff   <= 1'b0;
         light_ff     <= olb_pkg::LIGHT_RED;
         side_ff      <= 1'b0;
         countdown_ff <= olb_pkg::DELAY_BITS'(1);
         for (int k = 0; k < CROSS_TICKS; k++) begin
            slots_ff[k] <= '0;
         end
      end else begin
         north_ff     <= north_in;
         south_ff     <= south_in;
         bridge_ff    <= bridge_in;
         passed_ff    <= passed_in;
         heading_ff   <= heading_in;
         light_ff     <= light_in;
         side_ff      <= side_in;
         countdown_ff <= countdown_in;
         slots_ff     <= slots_in;
      end
   end

   assign result.light         = light_in;
   assign result.north_waiting = olb_pkg::OUT_BITS'(north_in);
   assign result.south_waiting = olb_pkg::OUT_BITS'(south_in);
   assign result.on_bridge     = olb_pkg::OUT_BITS'(bridge_in);
   assign result.travel_dir    = heading_in;
   assign result.error_flag    = err;

   a_countdown_nonzero: assert property (@(posedge clock) disable iff (reset)
      countdown_ff != '0)
      else $error("evaluation countdown reached zero");

   a_light_on_tick_only: assert property (@(posedge clock) disable iff (reset)
      !(fire && item.action == olb_pkg::ACT_TICK) |=> $stable(light_ff))
      else $error("light changed without a tick");

   a_red_clears_passed: assert property (@(posedge clock) disable iff (reset)
      (fire && light_ff != olb_pkg::LIGHT_RED && light_in == olb_pkg::LIGHT_RED)
      |=> passed_ff == '0)
      else $error("passed count not cleared on red");

   a_arrive_keeps_bridge: assert property (@(posedge clock) disable iff (reset)
      (fire && item.action == olb_pkg::ACT_ARRIVE) |=> $stable(bridge_ff))
      else $error("arrival changed the bridge count");

endmodule

[design/one_lane_bridge_light_control_unit.sv]
// Path: a transaction accepted into the input register passes through the update logic
//   into the result register, where it can be taken; a stalled sink holds it in place.
// Throughput: one transaction per cycle unless the response sink stalls; the event logic
//   is a single pass of counter updates and compares between input and result registers.
// Reset: synchronous, active high; clears all counts, the exit delay line and both
//   pipeline valids, sets the light red and the registers to their defaults.
module one_lane_bridge_light_control_unit #(
   parameter int CROSS_TICKS = 5,
   parameter int COUNT_BITS  = 8
) (
   input logic       clock,
   input logic       reset,
   olb_req_if.sink   req_chan,
   olb_rsp_if.source rsp_chan,
   olb_csr_if.sink   csr_chan
);

   // configuration registers
   olb_pkg::cfg_type    cfg_ff;

   // input stage
   logic                item_valid;
   olb_pkg::item_type   item;

   // result stage
   logic                rsp_valid_ff;
   olb_pkg::result_type result_ff;
   olb_pkg::result_type result;

   logic                advance;
   logic                fire;

   // Advance the pipe whenever the result register is empty or being drained.
   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign fire    = item_valid && advance;

   // Configuration writes are always taken; unknown addresses are dropped.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swap_limit      <= olb_pkg::SWAP_LIMIT_RESET;
         cfg_ff.recheck_ticks   <= olb_pkg::RECHECK_RESET;
         cfg_ff.clearance_ticks <= olb_pkg::CLEARANCE_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.addr)
            olb_pkg::CSR_SWAP_LIMIT: begin
               cfg_ff.swap_limit <= csr_chan.data;
            end
            olb_pkg::CSR_RECHECK: begin
               cfg_ff.recheck_ticks <= olb_pkg::DELAY_BITS'(csr_chan.data);
            end
            olb_pkg::CSR_CLEARANCE: begin
               cfg_ff.clearance_ticks <= olb_pkg::DELAY_BITS'(csr_chan.data);
            end
            default: begin
            end
         endcase
      end
   end

   // Hold the accepted transaction until the engine consumes it.
   olb_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Bridge state and the per-event update; the result is the post-update snapshot.
   olb_engine #(
      .CROSS_TICKS (CROSS_TICKS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Result register: load on advance, hold while the sink stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.light         = result_ff.light;
   assign rsp_chan.north_waiting = result_ff.north_waiting;
   assign rsp_chan.south_waiting = result_ff.south_waiting;
   assign rsp_chan.on_bridge     = result_ff.on_bridge;
   assign rsp_chan.travel_dir    = result_ff.travel_dir;
   assign rsp_chan.error_flag    = result_ff.error_flag;

endmodule
